[rtl/dcv_pkg.sv]
// Shared types, codes and calendar functions of the date and day number converter.
`timescale 1ns / 1ps

package dcv_pkg;

    localparam logic [1:0] CMD_DATE_TO_NUM = 2'd0;
    localparam logic [1:0] CMD_NUM_TO_DATE = 2'd1;
    localparam logic [1:0] CMD_DATE_ADD    = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] CENTURY_1   = 9'd100;
    localparam logic [8:0] CENTURY_2   = 9'd200;
    localparam logic [4:0] FEB_LEAP    = 5'd29;
    localparam logic [4:0] FEB_COMMON  = 5'd28;
    localparam logic [4:0] MONTH_30    = 5'd30;
    localparam logic [4:0] MONTH_31    = 5'd31;

    localparam logic [15:0] RECIP_YEAR  = 16'd45934;
    localparam int          RECIP_SHIFT = 24;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [17:0] value;
    } in_item_t;

    typedef struct packed {
        logic [16:0] num;
        logic [1:0]  status;
    } num_item_t;

    typedef struct packed {
        logic [7:0]  year;
        logic [8:0]  rem;
        logic        leap;
        logic [16:0] num;
        logic [1:0]  status;
    } year_item_t;

    typedef struct packed {
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [16:0] num;
        logic [1:0]  status;
    } out_item_t;

    function automatic logic leap_of(input logic [8:0] yoff);
        return (yoff[1:0] == 2'b00) && (yoff != CENTURY_1) && (yoff != CENTURY_2);
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? DAYS_LEAP : DAYS_COMMON;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
        logic [4:0] len;
        if (idx == 4'd1)
        begin
            len = leap ? FEB_LEAP : FEB_COMMON;
        end
        else if (idx inside {4'd3, 4'd5, 4'd8, 4'd10})
        begin
            len = MONTH_30;
        end
        else
        begin
            len = MONTH_31;
        end
        return len;
    endfunction

    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
    endfunction

    // Days from the start of year offset 0 to the start of year offset yoff.
    function automatic logic [16:0] days_before(input logic [8:0] yoff);
        logic [17:0] prod;
        logic [6:0]  quads;
        logic [1:0]  cents;
        logic [17:0] total;
        prod  = 18'(yoff) * 18'(DAYS_COMMON);
        quads = 7'((10'(yoff) + 10'd3) >> 2);
        if (yoff == 9'd0)
        begin
            cents = 2'd0;
        end
        else if (yoff <= CENTURY_1)
        begin
            cents = 2'd1;
        end
        else if (yoff <= CENTURY_2)
        begin
            cents = 2'd2;
        end
        else
        begin
            cents = 2'd3;
        end
        total = prod + 18'(quads) - 18'(cents) + 18'((yoff != 9'd0) ? 1 : 0);
        return total[16:0];
    endfunction

endpackage

[rtl/date_day_number_converter.sv]
// Top level of the Gregorian date and day number converter.
`timescale 1ns / 1ps

// Each transfer on the slave side gives exactly one transfer on the master side. The block
// is a seven-stage pipeline and takes a new transfer in every cycle; one shared advance
// signal moves all stages at once, so while the output register holds an untaken result
// the whole pipeline and s_tready stop. The depth is set by the year split: one stage
// multiplies by a reciprocal of the year length, one looks up the start of the estimated
// year and one corrects it. Valid years are offsets 0 to YEAR_SPAN-1; errors are reported
// in m_tuser with zero data.

module date_day_number_converter #(
    parameter int YEAR_SPAN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year_offset[7:0], month_in[11:8], day_in[16:12], day_value[34:17], zeros above.
    input  logic [39:0] s_tdata,
    // cmd[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // year_out[7:0], month_out[11:8], day_out[16:12], day_number[33:17], zeros above.
    output logic [39:0] m_tdata,
    // status[1:0].
    output logic [1:0]  m_tuser
);

    localparam logic [16:0] MAX_DAY = 17'(dcv_pkg::days_before(9'(YEAR_SPAN)) - 17'd1);

    logic                advance;
    dcv_pkg::in_item_t   in_item;
    logic                front_valid;
    dcv_pkg::num_item_t  front_item;
    logic                year_valid;
    dcv_pkg::year_item_t year_item;
    dcv_pkg::out_item_t  out_item;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    assign in_item.cmd   = s_tuser;
    assign in_item.year  = s_tdata[7:0];
    assign in_item.month = s_tdata[11:8];
    assign in_item.day   = s_tdata[16:12];
    assign in_item.value = s_tdata[34:17];

    dcv_front #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    dcv_year u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (year_valid),
        .out_item  (year_item)
    );

    dcv_month u_month (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (year_valid),
        .in_item   (year_item),
        .out_valid (m_tvalid),
        .out_item  (out_item)
    );

    assign m_tdata = {6'd0, out_item.num, out_item.day, out_item.month, out_item.year};
    assign m_tuser = out_item.status;

`ifndef NO_ASSERTIONS
    a_ok_month_day: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == dcv_pkg::STATUS_OK)) |->
        ((out_item.month >= 4'd1) && (out_item.month <= 4'd12) && (out_item.day != 5'd0)))
        else $error("Successful result has a month or day out of range.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != dcv_pkg::STATUS_OK)) |-> (m_tdata == 40'd0))
        else $error("Failed result carries nonzero data.");

    a_ok_span: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == dcv_pkg::STATUS_OK)) |->
        ((out_item.num <= MAX_DAY) && ({1'b0, out_item.year} < 9'(YEAR_SPAN))))
        else $error("Successful result lies outside the valid year span.");
`endif

endmodule

[rtl/dcv_front.sv]
// Input checks and date to day number stages of the converter.
`timescale 1ns / 1ps

module dcv_front #(
    parameter int YEAR_SPAN = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  dcv_pkg::in_item_t  in_item,
    output logic               out_valid,
    output dcv_pkg::num_item_t out_item
);

    localparam logic [16:0] MAX_DAY = 17'(dcv_pkg::days_before(9'(YEAR_SPAN)) - 17'd1);

    logic        a_valid_reg;
    logic [1:0]  a_cmd_reg;
    logic [1:0]  a_status_reg;
    logic [16:0] a_db_reg;
    logic [8:0]  a_cum_reg;
    logic [4:0]  a_day_reg;
    logic [17:0] a_val_reg;

    logic        b_valid_reg;
    logic [16:0] b_num_reg;
    logic [1:0]  b_status_reg;

    logic [8:0]  year9;
    logic        leap_a;
    logic        month_ok;
    logic [3:0]  midx;
    logic        date_ok;
    logic [1:0]  a_status_next;

    logic [16:0]        base;
    logic signed [18:0] base_s;
    logic signed [18:0] val_s;
    logic signed [18:0] target_s;
    logic               range_bad;
    logic [1:0]         b_status_next;

    always_comb
    begin
        year9    = {1'b0, in_item.year};
        leap_a   = dcv_pkg::leap_of(year9);
        month_ok = (in_item.month >= 4'd1) && (in_item.month <= 4'd12);
        midx     = month_ok ? (in_item.month - 4'd1) : 4'd0;
        date_ok  = (year9 < 9'(YEAR_SPAN)) && month_ok && (in_item.day != 5'd0)
                   && (in_item.day <= dcv_pkg::month_len(leap_a, midx));
        case (in_item.cmd)
            dcv_pkg::CMD_NUM_TO_DATE: a_status_next = dcv_pkg::STATUS_OK;
            dcv_pkg::CMD_DATE_TO_NUM,
            dcv_pkg::CMD_DATE_ADD:
                a_status_next = date_ok ? dcv_pkg::STATUS_OK : dcv_pkg::STATUS_BAD_DATE;
            default:                  a_status_next = dcv_pkg::STATUS_BAD_DATE;
        endcase
    end

    always_comb
    begin
        base   = a_db_reg + 17'(a_cum_reg) + 17'(a_day_reg) - 17'd1;
        base_s = $signed({2'b00, base});
        val_s  = $signed({a_val_reg[17], a_val_reg});
        case (a_cmd_reg)
            dcv_pkg::CMD_NUM_TO_DATE: target_s = val_s;
            dcv_pkg::CMD_DATE_ADD:    target_s = base_s + val_s;
            default:                  target_s = base_s;
        endcase
        range_bad = target_s[18] || (target_s[17:0] > {1'b0, MAX_DAY});
        if (a_status_reg != dcv_pkg::STATUS_OK)
        begin
            b_status_next = a_status_reg;
        end
        else if (range_bad)
        begin
            b_status_next = dcv_pkg::STATUS_RANGE;
        end
        else
        begin
            b_status_next = dcv_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_cmd_reg    <= in_item.cmd;
            a_status_reg <= a_status_next;
            a_db_reg     <= dcv_pkg::days_before(year9);
            a_cum_reg    <= dcv_pkg::cum_days(leap_a, midx);
            a_day_reg    <= in_item.day;
            a_val_reg    <= in_item.value;
            b_num_reg    <= target_s[16:0];
            b_status_reg <= b_status_next;
        end
    end

    assign out_valid       = b_valid_reg;
    assign out_item.num    = b_num_reg;
    assign out_item.status = b_status_reg;

endmodule

[rtl/dcv_year.sv]
// Year split stages: estimate, check and correct the year of a day number.
`timescale 1ns / 1ps

module dcv_year (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  dcv_pkg::num_item_t  in_item,
    output logic                out_valid,
    output dcv_pkg::year_item_t out_item
);

    logic        c_valid_reg;
    logic [8:0]  c_ye_reg;
    logic [16:0] c_num_reg;
    logic [1:0]  c_status_reg;

    logic        d_valid_reg;
    logic [8:0]  d_ye_reg;
    logic [16:0] d_db0_reg;
    logic        d_leap_prev_reg;
    logic        d_leap_cur_reg;
    logic        d_leap_next_reg;
    logic [16:0] d_num_reg;
    logic [1:0]  d_status_reg;

    logic        e_valid_reg;
    logic [7:0]  e_year_reg;
    logic [8:0]  e_rem_reg;
    logic        e_leap_reg;
    logic [16:0] e_num_reg;
    logic [1:0]  e_status_reg;

    logic [32:0]        prod;
    logic signed [17:0] diff;
    logic [17:0]        rem_wide;
    logic [8:0]         year_next;
    logic               leap_next;

    assign prod = 33'(in_item.num) * 33'(dcv_pkg::RECIP_YEAR);

    // The estimate is within one year of the true year, so one step corrects it.
    always_comb
    begin
        diff = $signed({1'b0, d_num_reg}) - $signed({1'b0, d_db0_reg});
        if (diff[17])
        begin
            year_next = d_ye_reg - 9'd1;
            leap_next = d_leap_prev_reg;
            rem_wide  = 18'(diff) + 18'(dcv_pkg::year_len(d_leap_prev_reg));
        end
        else if (18'(diff) >= 18'(dcv_pkg::year_len(d_leap_cur_reg)))
        begin
            year_next = d_ye_reg + 9'd1;
            leap_next = d_leap_next_reg;
            rem_wide  = 18'(diff) - 18'(dcv_pkg::year_len(d_leap_cur_reg));
        end
        else
        begin
            year_next = d_ye_reg;
            leap_next = d_leap_cur_reg;
            rem_wide  = 18'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_ye_reg        <= prod[dcv_pkg::RECIP_SHIFT +: 9];
            c_num_reg       <= in_item.num;
            c_status_reg    <= in_item.status;
            d_ye_reg        <= c_ye_reg;
            d_db0_reg       <= dcv_pkg::days_before(c_ye_reg);
            d_leap_prev_reg <= dcv_pkg::leap_of(c_ye_reg - 9'd1);
            d_leap_cur_reg  <= dcv_pkg::leap_of(c_ye_reg);
            d_leap_next_reg <= dcv_pkg::leap_of(c_ye_reg + 9'd1);
            d_num_reg       <= c_num_reg;
            d_status_reg    <= c_status_reg;
            e_year_reg      <= year_next[7:0];
            e_rem_reg       <= rem_wide[8:0];
            e_leap_reg      <= leap_next;
            e_num_reg       <= d_num_reg;
            e_status_reg    <= d_status_reg;
        end
    end

    assign out_valid       = e_valid_reg;
    assign out_item.year   = e_year_reg;
    assign out_item.rem    = e_rem_reg;
    assign out_item.leap   = e_leap_reg;
    assign out_item.num    = e_num_reg;
    assign out_item.status = e_status_reg;

endmodule

[rtl/dcv_month.sv]
// Month and day split stages, ending in the output register of the converter.
`timescale 1ns / 1ps

module dcv_month (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  dcv_pkg::year_item_t in_item,
    output logic                out_valid,
    output dcv_pkg::out_item_t  out_item
);

    logic        f_valid_reg;
    logic [3:0]  f_midx_reg;
    logic [8:0]  f_rem_reg;
    logic        f_leap_reg;
    logic [7:0]  f_year_reg;
    logic [16:0] f_num_reg;
    logic [1:0]  f_status_reg;

    logic               g_valid_reg;
    dcv_pkg::out_item_t g_item_reg;

    logic [3:0]         midx_next;
    logic [8:0]         day_wide;
    dcv_pkg::out_item_t g_item_next;

    always_comb
    begin
        midx_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            midx_next = midx_next
                        + 4'((in_item.rem >= dcv_pkg::cum_days(in_item.leap, 4'(k))) ? 1 : 0);
        end
    end

    always_comb
    begin
        day_wide = f_rem_reg - dcv_pkg::cum_days(f_leap_reg, f_midx_reg) + 9'd1;
        if (f_status_reg == dcv_pkg::STATUS_OK)
        begin
            g_item_next.year  = f_year_reg;
            g_item_next.month = f_midx_reg + 4'd1;
            g_item_next.day   = day_wide[4:0];
            g_item_next.num   = f_num_reg;
        end
        else
        begin
            g_item_next.year  = 8'd0;
            g_item_next.month = 4'd0;
            g_item_next.day   = 5'd0;
            g_item_next.num   = 17'd0;
        end
        g_item_next.status = f_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f_valid_reg <= in_valid;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f_midx_reg   <= midx_next;
            f_rem_reg    <= in_item.rem;
            f_leap_reg   <= in_item.leap;
            f_year_reg   <= in_item.year;
            f_num_reg    <= in_item.num;
            f_status_reg <= in_item.status;
            g_item_reg   <= g_item_next;
        end
    end

    assign out_valid = g_valid_reg;
    assign out_item  = g_item_reg;

endmodule

[tb/tb.sv]
// Self-checking testbench of the date and day number converter.
`timescale 1ns / 1ps

module tb;

    localparam int         YEAR_SPAN  = 256;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         N_RANDOM   = 1250;
    localparam int         HOLD_LEN   = 300;

    class date_scoreboard;
        dcv_pkg::out_item_t expected_dates[$];
        int        errors;
        int        n_checked;
        int        n_ok;
        int        n_bad;
        int        n_range;

        function new();
            errors = 0;
            n_checked = 0;
            n_ok = 0;
            n_bad = 0;
            n_range = 0;
        endfunction

        function bit is_leap(int yoff);
            int y;
            y = yoff + 2000;
            return ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
        endfunction

        function int year_days(int yoff);
            return is_leap(yoff) ? 366 : 365;
        endfunction

        function int month_days(bit lp, int m);
            int len;
            case (m)
                2:             len = lp ? 29 : 28;
                4, 6, 9, 11:   len = 30;
                default:       len = 31;
            endcase
            return len;
        endfunction

        function bit date_valid(int y, int m, int d);
            if (y >= YEAR_SPAN || m < 1 || m > 12 || d < 1)
            begin
                return 1'b0;
            end
            return d <= month_days(is_leap(y), m);
        endfunction

        function int days_from_date(int y, int m, int d);
            int n;
            n = d - 1;
            for (int i = 0; i < y; i++)
            begin
                n += year_days(i);
            end
            for (int i = 1; i < m; i++)
            begin
                n += month_days(is_leap(y), i);
            end
            return n;
        endfunction

        function dcv_pkg::out_item_t convert(dcv_pkg::in_item_t it);
            dcv_pkg::out_item_t r;
            int         val;
            int         last_day;
            int         target;
            int         n;
            int         yy;
            int         mm;
            logic [1:0] st;
            r = '0;
            st = dcv_pkg::STATUS_OK;
            target = 0;
            val = $signed(it.value);
            last_day = -1;
            for (int i = 0; i < YEAR_SPAN; i++)
            begin
                last_day += year_days(i);
            end
            if (it.cmd == CMD_UNUSED)
            begin
                st = dcv_pkg::STATUS_BAD_DATE;
            end
            else if (it.cmd == dcv_pkg::CMD_NUM_TO_DATE)
            begin
                if (val < 0 || val > last_day)
                    st = dcv_pkg::STATUS_RANGE;
                else
                    target = val;
            end
            else if (!date_valid(it.year, it.month, it.day))
            begin
                st = dcv_pkg::STATUS_BAD_DATE;
            end
            else
            begin
                target = days_from_date(it.year, it.month, it.day);
                if (it.cmd == dcv_pkg::CMD_DATE_ADD)
                    target += val;
                if (target < 0 || target > last_day)
                    st = dcv_pkg::STATUS_RANGE;
            end
            if (st == dcv_pkg::STATUS_OK)
            begin
                n = target;
                yy = 0;
                while (yy + 1 < YEAR_SPAN && n >= year_days(yy))
                begin
                    n -= year_days(yy);
                    yy++;
                end
                mm = 1;
                while (mm < 12 && n >= month_days(is_leap(yy), mm))
                begin
                    n -= month_days(is_leap(yy), mm);
                    mm++;
                end
                r.year = 8'(yy);
                r.month = 4'(mm);
                r.day = 5'(n + 1);
                r.num = 17'(target);
            end
            r.status = st;
            return r;
        endfunction

        function void note_request(dcv_pkg::in_item_t it);
            expected_dates.push_back(convert(it));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] error: %s", $time, msg);
        endtask

        task check_result(dcv_pkg::out_item_t got);
            dcv_pkg::out_item_t want;
            if (expected_dates.size() == 0)
            begin
                report($sformatf("result with no request pending, status %0d", got.status));
                return;
            end
            want = expected_dates.pop_front();
            n_checked++;
            case (want.status)
                dcv_pkg::STATUS_OK:       n_ok++;
                dcv_pkg::STATUS_BAD_DATE: n_bad++;
                default:                  n_range++;
            endcase
            if (got.year != want.year)
                report($sformatf("result %0d year expected %0d got %0d",
                                 n_checked, want.year, got.year));
            if (got.month != want.month)
                report($sformatf("result %0d month expected %0d got %0d",
                                 n_checked, want.month, got.month));
            if (got.day != want.day)
                report($sformatf("result %0d day expected %0d got %0d",
                                 n_checked, want.day, got.day));
            if (got.num != want.num)
                report($sformatf("result %0d day number expected %0d got %0d",
                                 n_checked, want.num, got.num));
            if (got.status != want.status)
                report($sformatf("result %0d status expected %0d got %0d",
                                 n_checked, want.status, got.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    date_scoreboard sb;
    bit             no_idle;
    bit             hold_req;

    date_day_number_converter #(
        .YEAR_SPAN(YEAR_SPAN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 36);
    endfunction

    function automatic dcv_pkg::in_item_t req(logic [1:0] cmd, int y, int m, int d, int v);
        dcv_pkg::in_item_t it;
        it.cmd = cmd;
        it.year = 8'(y);
        it.month = 4'(m);
        it.day = 5'(d);
        it.value = 18'(v);
        return it;
    endfunction

    function automatic dcv_pkg::in_item_t random_request();
        dcv_pkg::in_item_t it;
        int       pick;
        int       y;
        int       m;
        pick = $urandom_range(99);
        if (pick < 30)
            it.cmd = dcv_pkg::CMD_DATE_TO_NUM;
        else if (pick < 60)
            it.cmd = dcv_pkg::CMD_NUM_TO_DATE;
        else if (pick < 95)
            it.cmd = dcv_pkg::CMD_DATE_ADD;
        else
            it.cmd = CMD_UNUSED;
        pick = $urandom_range(9);
        y = (pick == 0) ? 0 : (pick == 1) ? YEAR_SPAN - 1 : $urandom_range(YEAR_SPAN - 1);
        if ($urandom_range(9) < 8)
        begin
            m = $urandom_range(12, 1);
            it.year = 8'(y);
            it.month = 4'(m);
            it.day = 5'($urandom_range(sb.month_days(sb.is_leap(y), m), 1));
        end
        else
        begin
            it.year = 8'($urandom_range(255));
            it.month = 4'($urandom_range(15));
            it.day = 5'($urandom_range(31));
        end
        pick = $urandom_range(99);
        if (it.cmd == dcv_pkg::CMD_NUM_TO_DATE)
        begin
            if (pick < 70)
                it.value = 18'($urandom_range(93501));
            else if (pick < 80)
                it.value = 18'(93498 + $urandom_range(6));
            else if (pick < 85)
                it.value = 18'(int'($urandom_range(6)) - 3);
            else
                it.value = 18'($urandom);
        end
        else if (it.cmd == dcv_pkg::CMD_DATE_ADD)
        begin
            if (pick < 40)
                it.value = 18'(int'($urandom_range(800)) - 400);
            else if (pick < 70)
                it.value = 18'(int'($urandom_range(187002)) - 93501);
            else
                it.value = 18'($urandom);
        end
        else
        begin
            it.value = 18'($urandom);
        end
        return it;
    endfunction

    task automatic send_request(input dcv_pkg::in_item_t it);
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, it.value, it.day, it.month, it.year};
        s_tuser <= it.cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                 hold_left;
        dcv_pkg::out_item_t got;
        hold_left = 0;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.year = m_tdata[7:0];
                got.month = m_tdata[11:8];
                got.day = m_tdata[16:12];
                got.num = m_tdata[33:17];
                got.status = m_tuser;
                sb.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !idle_now();
            end
        end
    end

    initial
    begin
        dcv_pkg::in_item_t directed[$];
        sb = new();
        no_idle = 1'b0;
        hold_req = 1'b0;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = dcv_pkg::CMD_DATE_TO_NUM;

        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 0, 1, 1, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 255, 12, 31, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 0, 2, 29, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 100, 2, 29, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 200, 2, 29, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 1, 2, 29, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 0, 0, 1, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 0, 15, 31, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 0, 1, 0, 0));
        directed.push_back(req(dcv_pkg::CMD_DATE_TO_NUM, 0, 4, 31, 0));
        directed.push_back(req(dcv_pkg::CMD_NUM_TO_DATE, 0, 0, 0, 0));
        directed.push_back(req(dcv_pkg::CMD_NUM_TO_DATE, 0, 0, 0, 93501));
        directed.push_back(req(dcv_pkg::CMD_NUM_TO_DATE, 0, 0, 0, 93502));
        directed.push_back(req(dcv_pkg::CMD_NUM_TO_DATE, 0, 0, 0, -1));
        directed.push_back(req(dcv_pkg::CMD_NUM_TO_DATE, 0, 0, 0, -131072));
        directed.push_back(req(dcv_pkg::CMD_NUM_TO_DATE, 0, 0, 0, 131071));
        directed.push_back(req(dcv_pkg::CMD_NUM_TO_DATE, 0, 0, 0, 59));
        directed.push_back(req(dcv_pkg::CMD_DATE_ADD, 0, 1, 1, -1));
        directed.push_back(req(dcv_pkg::CMD_DATE_ADD, 255, 12, 31, 1));
        directed.push_back(req(dcv_pkg::CMD_DATE_ADD, 255, 12, 31, -131072));
        directed.push_back(req(dcv_pkg::CMD_DATE_ADD, 0, 1, 1, 131071));
        directed.push_back(req(dcv_pkg::CMD_DATE_ADD, 0, 1, 1, 93501));
        directed.push_back(req(dcv_pkg::CMD_DATE_ADD, 255, 12, 31, -93501));
        directed.push_back(req(dcv_pkg::CMD_DATE_ADD, 0, 2, 30, 5));
        directed.push_back(req(CMD_UNUSED, 255, 15, 31, -1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 400)
                hold_req = 1'b1;
            if (i == 500)
                no_idle = 1'b1;
            if (i == 700)
                no_idle = 1'b0;
            if (i == 850)
                wait_drained();
            send_request(random_request());
        end

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Checked %0d results: %0d converted, %0d bad date or command, %0d out of range.",
                 sb.n_checked, sb.n_ok, sb.n_bad, sb.n_range);
        $display("The run covered a long output stall, a full drain and a stretch without idling.");
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
